>>> rtl/sha1_byte_stream_hasher_unit_assert.svh
// Assertion macros shared by the SHA-1 hasher checker.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SHA1_BYTE_STREAM_HASHER_UNIT_ASSERT_SVH
`define SHA1_BYTE_STREAM_HASHER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SHA1_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sha1 hasher: same-cycle check failed");

// next-cycle implication, disabled during reset
`define SHA1_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sha1 hasher: next-cycle check failed");

`endif

>>> rtl/sha1_pkg.sv
// Types, state encoding and constants of the SHA-1 byte stream hasher.
// Used by the top level and its port checker; depends on nothing.
package sha1_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } sha1_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha1_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } sha1_state_t;

    localparam logic [7:0] PAD_BYTE     = 8'h80;
    localparam logic [6:0] LAST_ROUND   = 7'd79;
    localparam logic [5:0] LAST_FILL    = 6'd63;
    localparam logic [2:0] LAST_WORD_IX = 3'd4;

    function automatic logic [31:0] sha1_iv(input logic [2:0] idx);
        logic [31:0] v;
        unique case (idx)
            3'd0:    v = 32'h67452301;
            3'd1:    v = 32'hefcdab89;
            3'd2:    v = 32'h98badcfe;
            3'd3:    v = 32'h10325476;
            3'd4:    v = 32'hc3d2e1f0;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] sha1_k(input logic [1:0] stage);
        logic [31:0] v;
        unique case (stage)
            2'd0: v = 32'h5a827999;
            2'd1: v = 32'h6ed9eba1;
            2'd2: v = 32'h8f1bbcdc;
            2'd3: v = 32'hca62c1d6;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/sha1_byte_stream_hasher_unit.sv
// SHA-1 byte stream hasher: byte packing, padding, round sequencer and digest output.
// Depends on sha1_pkg for transaction types, state encoding and constants.
//
// Each accepted transaction carries at most one message byte, which is shifted
// into a 512-bit window. Every 64th byte starts a compression of 80 rounds (one
// round per cycle through a single shared round adder) followed by the chaining
// add; s_ready is low throughout. End of message pads one byte per cycle up to
// the block end and compresses, plus a further 64-byte padded block and
// compression when the mark lands in the last eight byte slots, then holds
// s_ready low while the five digest words go out on m_data, H0 first, one per
// m_ready.
module sha1_byte_stream_hasher_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sha1_pkg::sha1_in_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sha1_pkg::sha1_out_t m_data
);

    sha1_pkg::sha1_state_t state_reg, state_next;

    logic [511:0] win_reg, win_next;
    logic [5:0]   fill_reg, fill_next;
    logic [63:0]  byte_count_reg, byte_count_next;
    logic [31:0]  chain_reg [5];
    logic [31:0]  chain_next [5];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  a_next, b_next, c_next, d_next, e_next;
    logic [6:0]   rnd_reg, rnd_next;
    logic [2:0]   out_idx_reg, out_idx_next;
    logic         pad_active_reg, pad_active_next;
    logic         pad_first_reg, pad_first_next;
    logic         len_ok_reg, len_ok_next;
    logic         len_done_reg, len_done_next;

    logic [63:0]  bit_count;
    logic [5:0]   len_shift;
    logic [63:0]  len_word;
    logic [7:0]   pad_byte;
    logic [31:0]  w0, w2, w8, w13, w_mix, w_new;
    logic [1:0]   stage;
    logic [31:0]  f_val, temp;

    assign bit_count = {byte_count_reg[60:0], 3'b000};
    assign len_shift = {~fill_reg[2:0], 3'b000};
    assign len_word  = bit_count >> len_shift;
    assign pad_byte  = pad_first_reg ? sha1_pkg::PAD_BYTE :
                       ((len_ok_reg && (fill_reg[5:3] == 3'b111)) ? len_word[7:0] : 8'h00);

    assign w0    = win_reg[511:480];
    assign w2    = win_reg[447:416];
    assign w8    = win_reg[255:224];
    assign w13   = win_reg[95:64];
    assign w_mix = w13 ^ w8 ^ w2 ^ w0;
    assign w_new = {w_mix[30:0], w_mix[31]};

    always_comb begin
        if (rnd_reg < 7'd20) begin
            stage = 2'd0;
        end else if (rnd_reg < 7'd40) begin
            stage = 2'd1;
        end else if (rnd_reg < 7'd60) begin
            stage = 2'd2;
        end else begin
            stage = 2'd3;
        end
        case (stage)
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd2:    f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            default: f_val = b_reg ^ c_reg ^ d_reg;
        endcase
        temp = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + sha1_pkg::sha1_k(stage) + w0;
    end

    always_comb begin
        state_next      = state_reg;
        win_next        = win_reg;
        fill_next       = fill_reg;
        byte_count_next = byte_count_reg;
        chain_next      = chain_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        c_next          = c_reg;
        d_next          = d_reg;
        e_next          = e_reg;
        rnd_next        = rnd_reg;
        out_idx_next    = out_idx_reg;
        pad_active_next = pad_active_reg;
        pad_first_next  = pad_first_reg;
        len_ok_next     = len_ok_reg;
        len_done_next   = len_done_reg;
        s_ready         = 1'b0;
        m_valid         = 1'b0;

        unique case (state_reg)
            sha1_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_data.byte_valid) begin
                        win_next        = {win_reg[503:0], s_data.data_byte};
                        byte_count_next = byte_count_reg + 64'd1;
                        fill_next       = fill_reg + 6'd1;
                    end
                    if (s_data.end_of_message) begin
                        pad_active_next = 1'b1;
                        pad_first_next  = 1'b1;
                        len_done_next   = 1'b0;
                    end
                    if (s_data.byte_valid && (fill_reg == sha1_pkg::LAST_FILL)) begin
                        state_next = sha1_pkg::ST_ROUND;
                        rnd_next   = 7'd0;
                        a_next     = chain_reg[0];
                        b_next     = chain_reg[1];
                        c_next     = chain_reg[2];
                        d_next     = chain_reg[3];
                        e_next     = chain_reg[4];
                    end else if (s_data.end_of_message) begin
                        state_next = sha1_pkg::ST_PAD;
                    end
                end
            end
            sha1_pkg::ST_PAD: begin
                win_next       = {win_reg[503:0], pad_byte};
                fill_next      = fill_reg + 6'd1;
                pad_first_next = 1'b0;
                if (pad_first_reg) begin
                    len_ok_next = (fill_reg[5:3] != 3'b111);
                end
                if (fill_reg == sha1_pkg::LAST_FILL) begin
                    len_done_next = len_ok_reg && !pad_first_reg;
                    len_ok_next   = 1'b1;
                    state_next    = sha1_pkg::ST_ROUND;
                    rnd_next      = 7'd0;
                    a_next        = chain_reg[0];
                    b_next        = chain_reg[1];
                    c_next        = chain_reg[2];
                    d_next        = chain_reg[3];
                    e_next        = chain_reg[4];
                end
            end
            sha1_pkg::ST_ROUND: begin
                win_next = {win_reg[479:0], w_new};
                e_next   = d_reg;
                d_next   = c_reg;
                c_next   = {b_reg[1:0], b_reg[31:2]};
                b_next   = a_reg;
                a_next   = temp;
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == sha1_pkg::LAST_ROUND) begin
                    state_next = sha1_pkg::ST_ADD;
                end
            end
            sha1_pkg::ST_ADD: begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                chain_next[4] = chain_reg[4] + e_reg;
                if (!pad_active_reg) begin
                    state_next = sha1_pkg::ST_IDLE;
                end else if (len_done_reg) begin
                    state_next   = sha1_pkg::ST_OUT;
                    out_idx_next = 3'd0;
                end else begin
                    state_next = sha1_pkg::ST_PAD;
                end
            end
            sha1_pkg::ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    chain_next[0] = chain_reg[1];
                    chain_next[1] = chain_reg[2];
                    chain_next[2] = chain_reg[3];
                    chain_next[3] = chain_reg[4];
                    chain_next[4] = sha1_pkg::sha1_iv(out_idx_reg);
                    out_idx_next  = out_idx_reg + 3'd1;
                    if (out_idx_reg == sha1_pkg::LAST_WORD_IX) begin
                        state_next      = sha1_pkg::ST_IDLE;
                        byte_count_next = 64'd0;
                        pad_active_next = 1'b0;
                        len_done_next   = 1'b0;
                    end
                end
            end
            default: begin
                state_next = sha1_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_data.digest_word = chain_reg[0];
    assign m_data.word_index  = out_idx_reg;
    assign m_data.last_word   = (out_idx_reg == sha1_pkg::LAST_WORD_IX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= sha1_pkg::ST_IDLE;
            fill_reg       <= 6'd0;
            byte_count_reg <= 64'd0;
            for (int i = 0; i < 5; i++) begin
                chain_reg[i] <= sha1_pkg::sha1_iv(3'(i));
            end
            rnd_reg        <= 7'd0;
            out_idx_reg    <= 3'd0;
            pad_active_reg <= 1'b0;
            pad_first_reg  <= 1'b0;
            len_ok_reg     <= 1'b0;
            len_done_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            byte_count_reg <= byte_count_next;
            chain_reg      <= chain_next;
            rnd_reg        <= rnd_next;
            out_idx_reg    <= out_idx_next;
            pad_active_reg <= pad_active_next;
            pad_first_reg  <= pad_first_next;
            len_ok_reg     <= len_ok_next;
            len_done_reg   <= len_done_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
    end

endmodule

>>> rtl/sha1_checker.sv
// Port-level checker for the SHA-1 hasher and its bind to the top level.
// Depends on sha1_pkg and the assertion macros in sha1_byte_stream_hasher_unit_assert.svh.
`include "sha1_byte_stream_hasher_unit_assert.svh"

module sha1_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input sha1_pkg::sha1_out_t m_data
);

    `SHA1_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `SHA1_ASSERT_NOW(a_no_in_during_out, aclk, aresetn, m_valid, !s_ready)
    `SHA1_ASSERT_NOW(a_last_flag, aclk, aresetn, m_valid, m_data.last_word == (m_data.word_index == sha1_pkg::LAST_WORD_IX))
    `SHA1_ASSERT_NEXT(a_word_order, aclk, aresetn, m_valid && m_ready && !m_data.last_word, m_valid && (m_data.word_index == $past(m_data.word_index) + 3'd1))
    `SHA1_ASSERT_NEXT(a_burst_end, aclk, aresetn, m_valid && m_ready && m_data.last_word, !m_valid)

endmodule

bind sha1_byte_stream_hasher_unit sha1_checker u_sha1_checker (.*);
